// ===== rtl/lbd_pkg.sv =====
// Package for the LED bar level frame driver.
// Holds opcode, result-kind and sequencer types, frame constants and the intensity table.
// No dependencies.
`default_nettype none

package lbd_pkg;

    localparam int LEDS_PER_BAR = 10;
    localparam int FRAME_WORDS  = 13;

    localparam logic [3:0] LAST_LED_WORD = 4'(LEDS_PER_BAR);
    localparam logic [3:0] LAST_WORD     = 4'(FRAME_WORDS - 1);
    localparam logic [3:0] LED_COUNT     = 4'(LEDS_PER_BAR);

    localparam logic [7:0] BYTE_OFF  = 8'h00;
    localparam logic [7:0] BYTE_LOW  = 8'h01;
    localparam logic [7:0] BYTE_MED  = 8'hAA;
    localparam logic [7:0] BYTE_HIGH = 8'hFF;
    localparam logic [7:0] CMD_WORD  = 8'h00;
    localparam logic [7:0] PAD_WORD  = 8'h00;

    typedef enum logic [1:0] {
        OP_SET_PIXEL = 2'd0,
        OP_SET_LEVEL = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_READ      = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_READ  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        DIR_FROM_FIRST = 2'd0,
        DIR_FROM_LAST  = 2'd1
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FRAME = 4'b0010,
        ST_MASK  = 4'b0100,
        ST_REPLY = 4'b1000
    } state_t;

    function automatic logic [7:0] code_byte(input logic [1:0] code);
        logic [7:0] b;
        case (code)
            2'd1:    b = BYTE_LOW;
            2'd2:    b = BYTE_MED;
            2'd3:    b = BYTE_HIGH;
            default: b = BYTE_OFF;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/led_bar_level_frame_driver_top.sv =====
// Top level of the LED bar level frame driver: command decode, brightness memory and
// frame sequencer with an output register. Depends on lbd_pkg.
`default_nettype none

//  channel | dir | handshake          | tdata (low bit up)                         | tuser
//  --------+-----+--------------------+--------------------------------------------+--------
//  s_      | in  | s_tvalid/s_tready  | bar[1:0] position[5:2] intensity[7:6]      | opcode
//          |     |                    | level[11:8] direction[13:12] zero[15:14]   |
//  m_      | out | m_tvalid/m_tready  | bar_out[1:0] frame_word[9:2]               | kind
//          |     |                    | lit_mask[19:10] zero[23:20]; tlast = latch |
//
//  Update commands (set pixel, set level, clear) go through an accept step and then
//  thirteen frame words, one per cycle while m_ is not stalled, paced by the walk over the
//  bar's ten memory entries (read one entry, write it back as its word leaves).
//  Read goes through accept, ten memory reads and the reply; a bad position goes straight to the reply.
//  Reset clears the per-entry valid bits at once, so every LED reads as off.
//  A stalled m_ channel holds the sequencer; one item is in work at a time.

module led_bar_level_frame_driver_top
    import lbd_pkg::*;
#(
    parameter int NUM_BARS = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // bar, position, intensity, level, direction
    input  wire logic [1:0]  s_tuser,   // opcode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // bar_out, frame_word, lit_mask
    output logic [1:0]       m_tuser,   // kind
    output logic             m_tlast    // latch
);

    localparam int DEPTH = NUM_BARS * LEDS_PER_BAR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Unpack the input item.
    logic [1:0] in_bar;
    logic [3:0] in_pos;
    logic [1:0] in_int;
    logic [3:0] in_lvl;
    logic [1:0] in_dir;
    logic       in_bar_ok;
    logic [AW-1:0] in_base;

    assign in_bar    = s_tdata[1:0];
    assign in_pos    = s_tdata[5:2];
    assign in_int    = s_tdata[7:6];
    assign in_lvl    = s_tdata[11:8];
    assign in_dir    = s_tdata[13:12];
    assign in_bar_ok = int'(in_bar) < NUM_BARS;
    assign in_base   = AW'(int'(in_bar) * LEDS_PER_BAR);

    // Command held for the duration of the item.
    state_t        state_reg, state_next;
    logic [3:0]    idx_reg, idx_next;
    opcode_t       op_reg;
    logic [1:0]    bar_reg;
    logic [AW-1:0] base_reg;
    logic [3:0]    pos_reg;
    logic [7:0]    val_reg;
    logic [3:0]    lvl_reg;
    logic [1:0]    dir_reg;
    logic [9:0]    mask_reg, mask_next;
    kind_t         reply_kind_reg, reply_kind_next;
    logic          cap;

    // Brightness memory with per-entry valid bits.
    logic [7:0]       bright_mem [DEPTH];
    logic [DEPTH-1:0] ent_valid_reg;
    logic [7:0]       rd_data_reg;
    logic             rd_valid_reg;
    logic             mem_we, mem_re;
    logic [AW-1:0]    waddr, raddr;

    // Output register.
    logic        m_tvalid_reg;
    logic [1:0]  m_bar_reg;
    logic [7:0]  m_word_reg;
    logic [9:0]  m_mask_reg;
    kind_t       m_kind_reg;
    logic        m_last_reg;
    logic        out_free, out_load;
    kind_t       o_kind;
    logic [7:0]  o_word;
    logic [9:0]  o_mask;
    logic        o_last;

    logic [3:0]  led_h;
    logic [7:0]  old_byte, new_byte;
    logic        lit_on;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign led_h    = idx_reg - 4'd1;
    assign old_byte = rd_valid_reg ? rd_data_reg : BYTE_OFF;

    // New byte of LED led_h for the command in work.
    always_comb begin
        case (dir_t'(dir_reg))
            DIR_FROM_FIRST: lit_on = led_h < lvl_reg;
            DIR_FROM_LAST:  lit_on = led_h >= (LED_COUNT - lvl_reg);
            default:        lit_on = 1'b0;
        endcase
        case (op_reg)
            OP_SET_PIXEL: new_byte = (led_h == pos_reg) ? val_reg : old_byte;
            OP_SET_LEVEL: new_byte = lit_on ? val_reg : BYTE_OFF;
            OP_CLEAR:     new_byte = BYTE_OFF;
            default:      new_byte = old_byte;
        endcase
    end

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        mask_next       = mask_reg;
        reply_kind_next = reply_kind_reg;
        cap             = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        raddr           = base_reg + AW'(idx_reg);
        waddr           = base_reg + AW'(led_h);
        out_load        = 1'b0;
        o_kind          = KIND_FRAME;
        o_word          = CMD_WORD;
        o_mask          = '0;
        o_last          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && in_bar_ok) begin
                    cap       = 1'b1;
                    mask_next = '0;
                    mem_re    = 1'b1;
                    raddr     = in_base;
                    case (opcode_t'(s_tuser))
                        OP_SET_PIXEL: begin
                            if (in_pos >= LED_COUNT) begin
                                reply_kind_next = KIND_ERROR;
                                state_next      = ST_REPLY;
                            end else begin
                                idx_next   = 4'd0;
                                state_next = ST_FRAME;
                            end
                        end
                        OP_READ: begin
                            reply_kind_next = KIND_READ;
                            idx_next        = 4'd1;
                            state_next      = ST_MASK;
                        end
                        default: begin
                            idx_next   = 4'd0;
                            state_next = ST_FRAME;
                        end
                    endcase
                end
            end
            ST_FRAME: begin
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + 4'd1;
                    if (idx_reg inside {[4'd1:LAST_LED_WORD]}) begin
                        // Write the LED back as its word leaves; fetch the next one.
                        o_word = new_byte;
                        mem_we = 1'b1;
                        mem_re = (idx_reg != LAST_LED_WORD);
                    end else if (idx_reg != 4'd0) begin
                        o_word = PAD_WORD;
                    end
                    if (idx_reg == LAST_WORD) begin
                        o_last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MASK: begin
                mask_next[led_h] = (old_byte != BYTE_OFF);
                if (idx_reg == LED_COUNT) begin
                    state_next = ST_REPLY;
                end else begin
                    mem_re   = 1'b1;
                    idx_next = idx_reg + 4'd1;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    o_kind     = reply_kind_reg;
                    o_word     = BYTE_OFF;
                    o_mask     = mask_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ent_valid_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_we) begin
                ent_valid_reg[waddr] <= 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        mask_reg       <= mask_next;
        reply_kind_reg <= reply_kind_next;
        if (cap) begin
            op_reg   <= opcode_t'(s_tuser);
            bar_reg  <= in_bar;
            base_reg <= in_base;
            pos_reg  <= in_pos;
            val_reg  <= code_byte(in_int);
            lvl_reg  <= (in_lvl > LED_COUNT) ? LED_COUNT : in_lvl;
            dir_reg  <= in_dir;
        end
        if (out_load) begin
            m_bar_reg  <= bar_reg;
            m_word_reg <= o_word;
            m_mask_reg <= o_mask;
            m_kind_reg <= o_kind;
            m_last_reg <= o_last;
        end
    end

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bright_mem[waddr] <= new_byte;
        end
        if (mem_re) begin
            rd_data_reg  <= bright_mem[raddr];
            rd_valid_reg <= ent_valid_reg[raddr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {4'd0, m_mask_reg, m_word_reg, m_bar_reg};

    // Checks.
    a_latch_on_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_FRAME)
        else $error("latch mark on a non-frame result");

    a_frame_no_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_FRAME |-> m_tdata[19:10] == 10'd0)
        else $error("frame word carries a lit mask");

    a_write_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> state_reg == ST_FRAME && idx_reg != 4'd0 && idx_reg <= LAST_LED_WORD)
        else $error("memory write outside the LED words of a frame");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FRAME |-> idx_reg <= LAST_WORD)
        else $error("frame word index out of range");

endmodule

`default_nettype wire
